### src/gpd_pkg.sv
package gpd_pkg;

    localparam int UNIFORM_BITS_DEF = 16;
    localparam int LOG_FRAC_BITS    = 24;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    localparam logic [15:0] MEAN_RESET = 16'sd0;
    localparam logic [14:0] DEV_RESET  = 15'd256;

    // Register indexes of the configuration port.
    localparam logic CFG_MEAN      = 1'b0;
    localparam logic CFG_DEVIATION = 1'b1;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_NORM   = 4'd2,
        OP_LOG    = 4'd3,
        OP_LMUL   = 4'd4,
        OP_DIV    = 4'd5,
        OP_QMUL   = 4'd6,
        OP_SQRT   = 4'd7,
        OP_SCALE  = 4'd8,
        OP_SUM    = 4'd9,
        OP_SPARE  = 4'd10
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_v;      // work on v rather than u
        logic keep_spare; // store the finished magnitude as the spare
        logic use_spare;  // scale the stored spare
    } t_cmd;

    typedef struct packed {
        logic reject;     // s is zero or at least one
        logic norm_done;  // s is normalised
        logic step_last;  // iteration counter at its final step
        logic spare_valid;
    } t_status;

endpackage

### src/gpd_if.sv
interface gpd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] uniform_u;
    logic [15:0] uniform_v;
    logic        sign_bit;
    modport source (output valid, uniform_u, uniform_v, sign_bit, input ready);
    modport sink   (input valid, uniform_u, uniform_v, sign_bit, output ready);
endinterface

interface gpd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] deviate_value;
    logic        from_spare;
    modport source (output valid, deviate_value, from_spare, input ready);
    modport sink   (input valid, deviate_value, from_spare, output ready);
endinterface

### src/gpd_datapath.sv
module gpd_datapath
    import gpd_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [15:0]             i_u,
    input  logic [15:0]             i_v,
    input  logic                    i_sign,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    output t_status                 o_status,
    output logic [23:0]             o_value,
    output logic                    o_from_spare
);

    // Alignment of the raw samples to Q0.16.
    localparam int DOWN_SHIFT = (UNIFORM_BITS >= 16) ? UNIFORM_BITS - 16 : 0;
    localparam int UP_SHIFT   = (UNIFORM_BITS < 16) ? 16 - UNIFORM_BITS : 0;
    localparam logic [15:0] RAW_MASK = (UNIFORM_BITS >= 16) ? 16'hFFFF
                                       : 16'((32'd1 << UNIFORM_BITS) - 32'd1);

    // Operands held for the whole item.
    logic [32:0] r_s, r_pu, r_pv;
    logic [32:0] r_m;
    logic [5:0]  r_k;
    logic [23:0] r_f;
    logic [31:0] r_l;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_q;
    logic [15:0] r_z, r_spare;
    logic        r_spare_valid;
    logic [5:0]  r_cnt;
    logic signed [15:0] r_mean;
    logic [14:0] r_dev;
    logic [31:0] r_scaled;
    logic [23:0] r_value;
    logic        r_from_spare;

    logic [15:0] u16, v16;
    logic [65:0] msq;
    logic [32:0] msh;
    logic [62:0] lprod;
    logic [63:0] qprod;
    logic [33:0] trial;
    logic [31:0] tz;
    logic signed [33:0] sum;
    logic [32:0] pick;

    // Bring inputs to Q0.16.
    assign u16 = 16'(({16'd0, i_u & RAW_MASK} << UP_SHIFT) >> DOWN_SHIFT);
    assign v16 = 16'(({16'd0, i_v & RAW_MASK} << UP_SHIFT) >> DOWN_SHIFT);

    // One squaring step of the logarithm, plus the products, trials and sum used by the other steps.
    assign msq   = {33'd0, r_m} * {33'd0, r_m};
    assign msh   = 33'(msq >> 31);
    assign lprod = {31'd0, r_l} * {32'd0, TWO_LN2_Q30};
    assign qprod = {32'd0, r_quo} * {32'd0, r_l};
    assign pick  = i_cmd.sel_v ? r_pv : r_pu;
    assign trial = {r_rem, 1'b0} - {1'b0, r_s};
    assign tz    = {16'd0, r_z | (16'd1 << r_cnt[3:0])};
    assign sum   = i_sign ? (34'(r_mean) - $signed({2'b0, r_scaled}))
                          : (34'(r_mean) + $signed({2'b0, r_scaled}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spare_valid <= 1'b0;
            r_spare       <= 16'd0;
            r_mean        <= MEAN_RESET;
            r_dev         <= DEV_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MEAN) r_mean <= i_cfg_data;
                else if (i_cfg_data[14:0] != 15'd0) r_dev <= i_cfg_data[14:0];
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_pu  <= {17'd0, u16} * {17'd0, u16};
                    r_pv  <= {17'd0, v16} * {17'd0, v16};
                    r_s   <= ({17'd0, u16} * {17'd0, u16}) + ({17'd0, v16} * {17'd0, v16});
                    r_m   <= ({17'd0, u16} * {17'd0, u16}) + ({17'd0, v16} * {17'd0, v16});
                    r_k   <= 6'd0;
                    r_f   <= 24'd0;
                    r_cnt <= 6'(LOG_FRAC_BITS - 1);
                end
                OP_NORM: begin
                    if (!r_m[31]) begin
                        r_m <= r_m << 1;
                        r_k <= r_k + 6'd1;
                    end
                end
                OP_LOG: begin
                    if (msh[32]) begin
                        r_m <= msh >> 1;
                        r_f <= {r_f[22:0], 1'b1};
                    end else begin
                        r_m <= msh;
                        r_f <= {r_f[22:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0)
                        r_l <= 32'((({26'd0, r_k} + 32'd1) << LOG_FRAC_BITS)
                               - {8'd0, r_f[22:0], msh[32]});
                end
                OP_LMUL: begin
                    r_l   <= 32'(lprod >> 30);
                    r_rem <= 33'd0;
                    r_quo <= 32'd0;
                    r_cnt <= 6'd63;
                end
                OP_DIV: begin
                    // Restoring division of p<<31 by s, one bit per cycle;
                    // the first cycle settles the integer bit.
                    if (r_cnt == 6'd63) begin
                        if (pick >= r_s) begin
                            r_rem <= pick - r_s;
                            r_quo <= 32'd1;
                        end else begin
                            r_rem <= pick;
                            r_quo <= 32'd0;
                        end
                        r_cnt <= 6'd30;
                    end else begin
                        if (!trial[33]) begin
                            r_rem <= trial[32:0];
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[31:0], 1'b0};
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                OP_QMUL: begin
                    r_q   <= 32'(qprod >> 31);
                    r_z   <= 16'd0;
                    r_cnt <= 6'd15;
                end
                OP_SQRT: begin
                    if ({32'd0, tz} * {32'd0, tz} <= {32'd0, r_q})
                        r_z <= tz[15:0];
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt[3:0] == 4'd0 && i_cmd.keep_spare) begin
                        r_spare       <= ({32'd0, tz} * {32'd0, tz} <= {32'd0, r_q})
                                         ? tz[15:0] : r_z;
                        r_spare_valid <= 1'b1;
                    end
                end
                OP_SCALE: begin
                    r_scaled <= 32'(({17'd0, i_cmd.use_spare ? r_spare : r_z}
                                    * {18'd0, r_dev} + 33'd2048) >> 12);
                    if (i_cmd.use_spare) r_spare_valid <= 1'b0;
                end
                OP_SUM: begin
                    if (sum > 34'sd8388607) r_value <= 24'h7FFFFF;
                    else if (sum < -34'sd8388608) r_value <= 24'h800000;
                    else r_value <= sum[23:0];
                    r_from_spare <= i_cmd.use_spare;
                end
                default: begin
                end
            endcase
        end
    end

    // Every counted iteration (log, divide, square root) counts down to zero at its final step.
    assign o_status.reject      = (r_s == 33'd0) || r_s[32];
    assign o_status.norm_done   = r_m[31];
    assign o_status.step_last   = (r_cnt == 6'd0);
    assign o_status.spare_valid = r_spare_valid;
    assign o_value      = r_value;
    assign o_from_spare = r_from_spare;

endmodule

### src/gpd_ctrl.sv
module gpd_ctrl
    import gpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHK   = 10'b0000000010,
        S_NORM  = 10'b0000000100,
        S_LOG   = 10'b0000001000,
        S_LMUL  = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_QMUL  = 10'b0001000000,
        S_SQRT  = 10'b0010000000,
        S_SCALE = 10'b0100000000,
        S_SUM   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second; // second pass computes u's magnitude
    logic   r_spare_item, n_spare_item;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_second     = r_second;
        n_spare_item = r_spare_item;
        n_out_valid  = r_out_valid;
        o_cmd        = '{op: OP_NONE, sel_v: !r_second, keep_spare: !r_second,
                         use_spare: r_spare_item};
        // The output register empties when its transaction is taken.
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_spare_item = i_status.spare_valid;
                n_second     = 1'b0;
                if (i_status.spare_valid) begin
                    n_state = S_SCALE;
                end else begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: n_state = i_status.reject ? S_IDLE : S_NORM;
            S_NORM: begin
                o_cmd.op = OP_NORM;
                if (i_status.norm_done) begin o_cmd.op = OP_NONE; n_state = S_LOG; end
            end
            S_LOG: begin
                o_cmd.op = OP_LOG;
                if (i_status.step_last) n_state = S_LMUL;
            end
            S_LMUL: begin o_cmd.op = OP_LMUL; n_state = S_DIV; end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_status.step_last) n_state = S_QMUL;
            end
            S_QMUL: begin o_cmd.op = OP_QMUL; n_state = S_SQRT; end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                // The count wraps to the divider's start mark for the second pass.
                if (i_status.step_last) begin
                    n_state  = r_second ? S_SCALE : S_DIV;
                    n_second = ~r_second;
                end
            end
            S_SCALE: begin o_cmd.op = OP_SCALE; n_state = S_SUM; end
            S_SUM: begin
                // Wait here while an earlier result still occupies the output.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_SUM;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_second     <= 1'b0;
            r_spare_item <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_second     <= n_second;
            r_spare_item <= n_spare_item;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_sum_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && (!r_out_valid || i_out_ready)) |=> (r_out_valid && o_in_ready))
        else $error("result skipped");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid) else $error("stall lost");
    a_reject_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && i_status.reject) |=> o_in_ready) else $error("reject path");

endmodule

### src/gaussian_polar_deviate_top.sv
// Gaussian deviate generator by the polar method.
// Input channel: uniform_u, uniform_v (Q0.UNIFORM_BITS) and sign_bit per
// transaction. Output channel: deviate_value (Q16.8, saturated) and
// from_spare. Configuration: write enable, index (0 mean, 1 deviation),
// data; write only while idle. A zero deviation write is ignored.
// A fresh pair passes these steps after acceptance: a check step, the
// normalising shifts, the log squaring steps (one per fraction bit), a
// multiply by 2 ln 2, then for each of v and u a restoring divider, a
// multiply and a bitwise square root, and last a scaling and a summing
// step. The next transaction can be accepted once the block is back in
// idle after the summing step.
// A rejected pair gives no result; the block goes back to idle from the
// check step.
// An item served from the stored spare goes from acceptance straight to
// the scaling and summing steps.
// One item is worked at a time; ready is high only when idle.
// A result waits in the output register until taken while the next item is
// worked; if the receiver still stalls, that item waits at its summing step
// and the input stays not ready.
// Reset clears the spare, sets mean to 0 and deviation to 1.0.
module gaussian_polar_deviate_top
    import gpd_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpd_in_if.sink      i_in,
    gpd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // Capture the sign at acceptance.
    logic r_sign;
    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) r_sign <= i_in.sign_bit;
    end

    gpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (status),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    gpd_datapath #(.UNIFORM_BITS(UNIFORM_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_u          (i_in.uniform_u),
        .i_v          (i_in.uniform_v),
        .i_sign       (r_sign),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_status     (status),
        .o_value      (o_out.deviate_value),
        .o_from_spare (o_out.from_spare)
    );

    assign i_in.ready = in_ready;

endmodule
